/* hdl/arithmetic_run_scatter_planner_assert.svh */
// Assertion macros for the arithmetic run scatter planner.
`ifndef ARITHMETIC_RUN_SCATTER_PLANNER_ASSERT_SVH
`define ARITHMETIC_RUN_SCATTER_PLANNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ARSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("planner check failed: same-cycle rule");

// Next-cycle implication, checked outside reset.
`define ARSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("planner check failed: next-cycle rule");

`endif

/* hdl/arsp_pkg.sv */
// Shared widths and run descriptor type for the arithmetic run scatter planner.
package arsp_pkg;

  localparam int ID_W  = 6;
  localparam int CNT_W = 7;

  // One arithmetic run: stride, start id and member count
  typedef struct packed {
    logic [ID_W-1:0]  stride;
    logic [ID_W-1:0]  start;
    logic [CNT_W-1:0] len;
  } arsp_run_t;

endpackage

/* hdl/arithmetic_run_scatter_planner.sv */
// Items load one per cycle while in the load state; the closing item starts the plan.
// Each pick sweeps every stride, one run extension step per cycle, then each
// member passes through the read state and then the output state, which waits for out_ready.
// A rejected batch gives its single result in the cycle after the closing item.
// Reset clears the presence map and counters and sets the token space register to 64.
// Arrival indices hold no reset value.
module arithmetic_run_scatter_planner #(
  parameter int MAX_TOKENS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [arsp_pkg::CNT_W-1:0]   token_space,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [arsp_pkg::ID_W-1:0]    token_id,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         status,
  output logic [arsp_pkg::ID_W-1:0]    column,
  output logic [arsp_pkg::ID_W-1:0]    orig_index,
  output logic [arsp_pkg::ID_W-1:0]    token_value,
  output logic                         seg_first,
  output logic [arsp_pkg::ID_W-1:0]    seg_src,
  output logic [arsp_pkg::ID_W-1:0]    seg_dst,
  output logic [arsp_pkg::CNT_W-1:0]   seg_len,
  output logic [arsp_pkg::ID_W-1:0]    seg_stride,
  output logic                         plan_last
);
  import arsp_pkg::*;

  `include "arithmetic_run_scatter_planner_assert.svh"

  localparam int IW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_TOKENS);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_SRCH = 4'b0010,
    S_RD   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                state;
  logic [MAX_TOKENS-1:0] present;
  logic [ID_W-1:0]       arrival [MAX_TOKENS];
  logic [ID_W-1:0]       arr_q;
  logic [CNT_W-1:0]      loaded_count;
  logic                  reject_flag;
  logic [CNT_W-1:0]      column_count;
  logic [CNT_W-1:0]      space_q;
  logic                  rej;
  logic                  go;
  arsp_run_t             run;
  logic [CNT_W-1:0]      i;
  logic [ID_W-1:0]       v;
  logic [ID_W-1:0]       src;

  logic                  srch_done;
  arsp_run_t             srch_best;

  logic                  in_acc;
  logic                  out_acc;
  logic [IW-1:0]         id_idx;
  logic [IW-1:0]         v_idx;
  logic                  id_ok;
  logic                  last_member;
  logic [MAX_TOKENS-1:0] remaining;

  arsp_search #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .present(present),
    .done   (srch_done),
    .best   (srch_best)
  );

  // Handshakes and per-item checks
  always_comb begin
    cfg_ready   = 1'b1;
    in_ready    = (state == S_LOAD);
    out_valid   = (state == S_OUT);
    in_acc      = in_valid && in_ready;
    out_acc     = out_valid && out_ready;
    id_idx      = token_id[IW-1:0];
    v_idx       = v[IW-1:0];
    id_ok       = !reject_flag && ({1'b0, token_id} < space_q) &&
                  ({1'b0, token_id} < MAX_C) && !present[id_idx];
    last_member = (i == run.len - CNT_W'(1));
    remaining   = present & ~({{(MAX_TOKENS-1){1'b0}}, 1'b1} << v_idx);
  end

  // Result fields; a rejection shows zeros apart from status and plan_last
  always_comb begin
    status      = rej;
    column      = rej ? '0 : column_count[ID_W-1:0];
    orig_index  = rej ? '0 : arr_q;
    token_value = rej ? '0 : v;
    seg_first   = !rej && (i == '0);
    seg_src     = rej ? '0 : src;
    seg_dst     = rej ? '0 : run.start;
    seg_len     = rej ? '0 : run.len;
    seg_stride  = rej ? '0 : run.stride;
    plan_last   = rej || (last_member && (remaining == '0));
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      space_q <= CNT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      space_q <= token_space;
    end
  end

  // Arrival index store: write on load, registered read per member
  always_ff @(posedge clk) begin
    if (in_acc && id_ok) begin
      arrival[id_idx] <= loaded_count[ID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      arr_q <= arrival[v_idx];
    end
  end

  // Start a search on a clean closing item or when members remain after a run
  always_ff @(posedge clk) begin
    if (rst) begin
      go <= 1'b0;
    end else begin
      go <= (in_acc && last && id_ok) ||
            (out_acc && !rej && last_member && (remaining != '0));
    end
  end

  // Sequencer: load, search, read, present
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      present      <= '0;
      loaded_count <= '0;
      reject_flag  <= 1'b0;
      column_count <= '0;
      rej          <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (last) begin
              loaded_count <= '0;
              reject_flag  <= 1'b0;
              column_count <= '0;
              if (!id_ok) begin
                rej     <= 1'b1;
                present <= '0;
                state   <= S_OUT;
              end else begin
                present[id_idx] <= 1'b1;
                state           <= S_SRCH;
              end
            end else begin
              if (id_ok) begin
                present[id_idx] <= 1'b1;
              end else begin
                reject_flag <= 1'b1;
              end
              if (loaded_count < MAX_C) loaded_count <= loaded_count + CNT_W'(1);
            end
          end
        end
        S_SRCH: begin
          if (srch_done) begin
            run   <= srch_best;
            i     <= '0;
            v     <= srch_best.start;
            src   <= column_count[ID_W-1:0];
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) begin
            if (rej) begin
              rej   <= 1'b0;
              state <= S_LOAD;
            end else begin
              present[v_idx] <= 1'b0;
              column_count   <= column_count + CNT_W'(1);
              if (last_member) begin
                if (remaining == '0) begin
                  state <= S_LOAD;
                end else begin
                  state <= S_SRCH;
                end
              end else begin
                i     <= i + CNT_W'(1);
                v     <= v + run.stride;
                state <= S_RD;
              end
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // A plan entry always names an id still in the map
  `ARSP_ASSERT_NOW(a_entry_present, out_valid && !status, present[v_idx])
  // Loading and presenting never overlap
  `ARSP_ASSERT_NOW(a_no_overlap, in_ready, !out_valid)
  // The final result of a batch hands back to loading with an empty map
  `ARSP_ASSERT_NEXT(a_plan_end, out_valid && out_ready && plan_last,
                    in_ready && (present == '0))

endmodule

/* hdl/arsp_search.sv */
// Longest-run search over the presence map, one run extension step per cycle.
module arsp_search #(
  parameter int MAX_TOKENS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [MAX_TOKENS-1:0] present,
  output logic                  done,
  output arsp_pkg::arsp_run_t   best
);
  import arsp_pkg::*;

  localparam logic [CNT_W-1:0] MAX_C  = CNT_W'(MAX_TOKENS);
  localparam logic [CNT_W-1:0] LAST_D = CNT_W'(MAX_TOKENS - 1);

  logic                  busy;
  logic [CNT_W-1:0]      d;
  logic [CNT_W-1:0]      k;
  logic [CNT_W-1:0]      sh;
  logic [MAX_TOKENS-1:0] r;

  logic [CNT_W-1:0]      sh_next;
  logic [MAX_TOKENS-1:0] cand;
  logic                  extend;
  logic [ID_W-1:0]       low_start;

  // Lowest start still alive at this stride
  function automatic logic [ID_W-1:0] low_bit(input logic [MAX_TOKENS-1:0] vec);
    logic [ID_W-1:0] idx;
    idx = '0;
    for (int i = MAX_TOKENS - 1; i >= 0; i--) begin
      if (vec[i]) idx = ID_W'(i);
    end
    return idx;
  endfunction

  // Shared shift-and-mask step: starts whose run reaches one more member
  always_comb begin
    sh_next   = sh + d;
    cand      = r & (present >> sh_next);
    extend    = (sh_next < MAX_C) && (cand != '0);
    low_start = low_bit(r);
  end

  // Sweep strides in ascending order, extending runs one member per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      if (go) begin
        busy     <= 1'b1;
        d        <= CNT_W'(1);
        k        <= CNT_W'(1);
        sh       <= '0;
        r        <= present;
        best.len <= '0;
      end else if (busy) begin
        if (extend) begin
          r  <= cand;
          k  <= k + CNT_W'(1);
          sh <= sh_next;
        end else begin
          if (k > best.len) begin
            best.len    <= k;
            best.stride <= d[ID_W-1:0];
            best.start  <= low_start;
          end
          if (d == LAST_D) begin
            busy <= 1'b0;
          end else begin
            d  <= d + CNT_W'(1);
            k  <= CNT_W'(1);
            sh <= '0;
            r  <= present;
          end
        end
      end
    end
  end

  // Flag the end of the sweep after the last stride closes
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy && !go && !extend && (d == LAST_D);
    end
  end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the arithmetic run scatter planner.
`timescale 1ns / 1ps

module tb;

  import arsp_pkg::*;

  localparam int NTOK      = 64;
  localparam int MAX_ERR   = 10;
  localparam int LIMIT     = 4000000;
  localparam bit ST_PLAN   = 1'b0;
  localparam bit ST_REJECT = 1'b1;

  typedef struct packed {
    logic             status;
    logic [ID_W-1:0]  column;
    logic [ID_W-1:0]  orig_index;
    logic [ID_W-1:0]  token_value;
    logic             seg_first;
    logic [ID_W-1:0]  seg_src;
    logic [ID_W-1:0]  seg_dst;
    logic [CNT_W-1:0] seg_len;
    logic [ID_W-1:0]  seg_stride;
    logic             plan_last;
  } plan_entry_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            fin;
    bit              typed;
    plan_entry_t     want;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] token_space;
  logic             in_valid;
  logic             in_ready;
  logic [ID_W-1:0]  token_id;
  logic             last;
  logic             out_valid;
  logic             out_ready;
  logic             status;
  logic [ID_W-1:0]  column;
  logic [ID_W-1:0]  orig_index;
  logic [ID_W-1:0]  token_value;
  logic             seg_first;
  logic [ID_W-1:0]  seg_src;
  logic [ID_W-1:0]  seg_dst;
  logic [CNT_W-1:0] seg_len;
  logic [ID_W-1:0]  seg_stride;
  logic             plan_last;

  arithmetic_run_scatter_planner u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .token_space(token_space),
    .in_valid(in_valid), .in_ready(in_ready), .token_id(token_id), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .column(column), .orig_index(orig_index),
    .token_value(token_value), .seg_first(seg_first), .seg_src(seg_src),
    .seg_dst(seg_dst), .seg_len(seg_len), .seg_stride(seg_stride),
    .plan_last(plan_last)
  );

  // Planner mirror state
  bit              pm_present [NTOK];
  logic [ID_W-1:0] pm_arrival [NTOK];
  int              pm_loaded;
  bit              pm_reject;
  int              pm_space;

  plan_entry_t plan_q[$];
  int          mismatches;
  int          typed_err;
  int          cycles;
  bit          hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int run_len(int v, int d);
    int n;
    n = 0;
    while (v < NTOK && pm_present[v]) begin
      n++;
      v += d;
    end
    return n;
  endfunction

  // Advance the mirror by one item and queue the entries it causes
  task automatic plan_item(input logic [ID_W-1:0] id, input logic fin);
    plan_entry_t e;
    int d, v, n, b_len, b_d, b_v, col, src, i;
    if (!pm_reject) begin
      if (id >= pm_space || pm_present[id]) pm_reject = 1'b1;
      else begin
        pm_present[id] = 1'b1;
        pm_arrival[id] = pm_loaded[ID_W-1:0];
      end
    end
    if (pm_loaded < NTOK) pm_loaded++;
    if (!fin) return;
    if (pm_reject) begin
      e = '0;
      e.status = ST_REJECT;
      e.plan_last = 1'b1;
      plan_q = {plan_q, e};
    end else begin
      col = 0;
      forever begin
        b_len = 0; b_d = 1; b_v = 0;
        for (d = 1; d < NTOK; d++)
          for (v = 0; v < NTOK; v++) begin
            if (!pm_present[v]) continue;
            if (v >= d && pm_present[v-d]) continue;
            n = run_len(v, d);
            if (n > b_len) begin
              b_len = n; b_d = d; b_v = v;
            end
          end
        if (b_len == 0) break;
        src = col;
        for (i = 0; i < b_len; i++) begin
          v = b_v + i * b_d;
          e.status = ST_PLAN;
          e.column = col[ID_W-1:0];
          e.orig_index = pm_arrival[v];
          e.token_value = v[ID_W-1:0];
          e.seg_first = (i == 0);
          e.seg_src = src[ID_W-1:0];
          e.seg_dst = b_v[ID_W-1:0];
          e.seg_len = b_len[CNT_W-1:0];
          e.seg_stride = b_d[ID_W-1:0];
          e.plan_last = 1'b0;
          pm_present[v] = 1'b0;
          plan_q = {plan_q, e};
          col++;
        end
      end
      plan_q[$].plan_last = 1'b1;
    end
    pm_present = '{default: 0};
    pm_loaded = 0;
    pm_reject = 1'b0;
  endtask

  // Check each accepted entry against the oldest expectation
  always @(posedge clk) begin
    plan_entry_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{status, column, orig_index, token_value, seg_first, seg_src,
              seg_dst, seg_len, seg_stride, plan_last};
      if (plan_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_ERR) $display("unexpected entry %p", got);
      end else begin
        if (got !== plan_q[0]) begin
          mismatches++;
          if (mismatches <= MAX_ERR)
            $display("entry mismatch: expected %p got %p", plan_q[0], got);
        end
        void'(plan_q.pop_front());
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ready <= 1'b1;
    else if ($urandom_range(0, 9) < 6) out_ready <= 1'b1;
    else out_ready <= 1'b0;
  end

  task automatic wait_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  // Offer one item; valid stays up afterwards so items can follow back to back
  task automatic send_item(input logic [ID_W-1:0] id, input logic fin);
    int gap;
    if ($urandom_range(0, 9) < 3) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                         : $urandom_range(1, 3);
      in_valid <= 1'b0;
      wait_cycles(gap);
    end
    in_valid <= 1'b1;
    token_id <= id;
    last <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    plan_item(id, fin);
  endtask

  // Write the token space once every expected entry has drained
  task automatic set_space(input int val);
    in_valid <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk);
    wait_cycles(20);
    cfg_valid <= 1'b1;
    token_space <= val[CNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pm_space = (val > NTOK) ? NTOK : val;
  endtask

  // Send a batch of distinct ids with random content
  task automatic send_batch(input int len, input int space);
    int ids[$];
    int k, j, t;
    for (k = 0; k < space; k++) ids = {ids, k};
    for (k = ids.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = ids[k]; ids[k] = ids[j]; ids[j] = t;
    end
    if (len > ids.size()) len = ids.size();
    for (k = 0; k < len; k++) send_item(ids[k][ID_W-1:0], k == len - 1);
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t mk(input int id, input bit fin);
    stim_row_t r;
    r.id = id[ID_W-1:0];
    r.fin = fin;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  initial begin
    int k, len, sent, kind;
    stim_row_t r;
    plan_entry_t rej;
    rst = 1'b1;
    cfg_valid = 1'b0;
    token_space = 7'd64;
    in_valid = 1'b0;
    token_id = '0;
    last = 1'b0;
    out_ready = 1'b0;
    hold_off = 1'b0;
    typed_err = 0;
    pm_present = '{default: 0};
    pm_loaded = 0;
    pm_reject = 1'b0;
    pm_space = NTOK;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rej = '0;
    rej.status = ST_REJECT;
    rej.plan_last = 1'b1;

    // Directed table: singleton extremes, a run, duplicate, reject-then-ignore
    dir_rows = {dir_rows, mk(0, 1)};
    dir_rows = {dir_rows, mk(63, 1)};
    dir_rows = {dir_rows, mk(5, 0)};
    dir_rows = {dir_rows, mk(1, 0)};
    dir_rows = {dir_rows, mk(9, 0)};
    dir_rows = {dir_rows, mk(13, 1)};
    dir_rows = {dir_rows, mk(7, 0)};
    r = mk(7, 1); r.typed = 1'b1; r.want = rej;
    dir_rows = {dir_rows, r};
    dir_rows = {dir_rows, mk(42, 0)};
    dir_rows = {dir_rows, mk(42, 0)};
    dir_rows = {dir_rows, mk(21, 0)};
    dir_rows = {dir_rows, mk(0, 0)};
    dir_rows = {dir_rows, mk(2, 0)};
    dir_rows = {dir_rows, mk(62, 0)};
    dir_rows = {dir_rows, mk(60, 1)};
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].id, dir_rows[i].fin);
      if (dir_rows[i].typed && plan_q.size() != 0 && plan_q[$] !== dir_rows[i].want) begin
        typed_err++;
        $display("typed row %0d: expected %p got %p", i, dir_rows[i].want, plan_q[$]);
      end
    end

    // Small token space: ids at and over the bound reject
    set_space(4);
    send_item(6'd3, 1'b0);
    send_item(6'd4, 1'b1);
    send_item(6'd2, 1'b0);
    send_item(6'd0, 1'b1);
    set_space(0);
    send_item(6'd0, 1'b1);
    set_space(1);
    send_item(6'd0, 1'b1);
    set_space(64);
    // Full batch of 64 ids, then one more past saturation
    for (k = 0; k < 64; k++) send_item(k[ID_W-1:0], 1'b0);
    send_item(6'd17, 1'b1);

    // Long receiver stall while batches keep arriving
    hold_off = 1'b1;
    fork
      begin
        send_batch(20, 64);
        send_batch(12, 64);
        in_valid <= 1'b0;
      end
      begin
        wait_cycles(3000);
        hold_off = 1'b0;
      end
    join

    // Random batches: mostly well-formed, some with bad or repeated ids
    sent = 0;
    while (sent < 290) begin
      if ($urandom_range(0, 14) == 0) begin
        case ($urandom_range(0, 3))
          0: set_space(64);
          1: set_space($urandom_range(1, 63));
          2: set_space($urandom_range(65, 127));
          default: set_space($urandom_range(8, 40));
        endcase
      end
      kind = $urandom_range(0, 9);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
      if (kind < 7) begin
        send_batch(len, pm_space);
        sent += (len > pm_space) ? pm_space : len;
        if (pm_space == 0) begin
          send_item(ID_W'($urandom_range(0, 63)), 1'b1);
          sent++;
        end
      end else begin
        for (k = 0; k < len; k++) begin
          send_item(ID_W'($urandom_range(0, 63)), k == len - 1);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk);
    wait_cycles(100);
    if (mismatches == 0 && typed_err == 0 && plan_q.size() == 0)
      $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
